>>> src/bte_pkg.sv
// Shared types, constants and helper functions for the burst to word expander.
// No dependencies.
package bte_pkg;

  localparam int ISSUE_LANES = 4;
  localparam int MAX_WORDS = 16;
  localparam int HELD_DEPTH = 32;
  localparam int LANE_CAP = 4;
  localparam int NUM_LANES = (ISSUE_LANES < LANE_CAP) ? ISSUE_LANES : LANE_CAP;
  localparam int MAX_RESULTS = 6;
  localparam int RES_CW = $clog2(MAX_RESULTS + 1);
  localparam logic [7:0] MAX_BYTES = 8'(4 * MAX_WORDS);

  typedef enum logic [1:0] {
    KIND_ACCEPT,
    KIND_DENY,
    KIND_ISSUE,
    KIND_BEAT
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [1:0]  lane;
    logic [31:0] sub_addr;
    logic [2:0]  sub_size;
    logic        sub_is_write;
    logic [3:0]  sub_opcode;
    logic        context_id;
    logic [3:0]  word_index;
    logic        burst_done;
    logic        last;
  } result_t;

  typedef struct packed {
    logic       ctx;
    logic [3:0] word;
  } tag_t;

  typedef struct packed {
    logic push_req;
    tag_t push_tag;
    logic pop_req;
  } fifo_ctl_t;

  typedef struct packed {
    logic pop_valid;
    tag_t pop_tag;
  } fifo_sts_t;

  function automatic logic [5:0] ctx_words(input logic [6:0] size);
    logic [7:0] sum;
    sum = {1'b0, size} + 8'd3;
    return sum[7:2];
  endfunction

  function automatic result_t make_offer(input logic [1:0] lane, input logic [31:0] base,
                                         input logic [6:0] size, input logic wr,
                                         input logic [3:0] op, input logic ctx,
                                         input logic [3:0] word);
    result_t r;
    logic [7:0] off;
    logic [7:0] left;
    off = {2'b00, word, 2'b00};
    left = {1'b0, size} - off;
    r = '0;
    r.kind = KIND_ISSUE;
    r.lane = lane;
    r.sub_addr = base + {24'b0, off};
    r.sub_size = ({1'b0, size} >= off && left < 8'd4) ? left[2:0] : 3'd4;
    r.sub_is_write = wr;
    r.sub_opcode = op;
    r.context_id = ctx;
    r.word_index = word;
    return r;
  endfunction

endpackage

>>> src/burst_to_word_expander.sv
// Top level of the burst to word expander: core logic, completion queue, result buffer.
// Depends on bte_pkg, bte_core, bte_held_fifo, bte_result_buf.
//
// Each input transaction is one cycle of the downstream interface: it is taken in one
// step and all its effects (accept or deny, up to one sub-request per lane, one upstream
// beat) are computed by combinational logic and loaded into a result buffer. Results leave
// one per cycle while out_ready is high; a transaction holds the input until they are out;
// transactions with no results flow at one per cycle. The next transaction is accepted in
// the cycle the last pending result is taken. Completions are queued in a HELD_DEPTH-entry
// FIFO; a completion arriving while it is full is dropped.
module burst_to_word_expander #(
  parameter int HELD_DEPTH = bte_pkg::HELD_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [31:0] req_addr,
  input  logic [6:0]  req_size,
  input  logic        req_is_write,
  input  logic [3:0]  req_opcode,
  input  logic [3:0]  lane_grant_mask,
  input  logic [3:0]  lane_reopen_mask,
  input  logic        done_valid,
  input  logic        done_context,
  input  logic [3:0]  done_word,
  input  logic        upstream_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [1:0]  lane,
  output logic [31:0] sub_addr,
  output logic [2:0]  sub_size,
  output logic        sub_is_write,
  output logic [3:0]  sub_opcode,
  output logic        context_id,
  output logic [3:0]  word_index,
  output logic        burst_done,
  output logic        last
);

  logic                       fire;
  bte_pkg::fifo_ctl_t         fifo_ctl;
  bte_pkg::fifo_sts_t         fifo_sts;
  bte_pkg::result_t           res [bte_pkg::MAX_RESULTS];
  logic [bte_pkg::RES_CW-1:0] res_count;
  bte_pkg::result_t           head;

  assign fire = in_valid && in_ready;

  bte_core u_core (
    .clk, .rst, .cfg_we, .cfg_wdata, .fire,
    .cmd, .req_addr, .req_size, .req_is_write, .req_opcode,
    .lane_grant_mask, .lane_reopen_mask, .done_valid, .done_context, .done_word,
    .upstream_ready, .fifo_ctl, .fifo_sts, .res, .res_count
  );

  bte_held_fifo #(.DEPTH(HELD_DEPTH)) u_fifo (
    .clk, .rst, .ctl(fifo_ctl), .sts(fifo_sts)
  );

  bte_result_buf u_rbuf (
    .clk, .rst, .load(fire), .res, .res_count, .space(in_ready),
    .out_valid, .out_ready, .head
  );

  assign kind = head.kind;
  assign lane = head.lane;
  assign sub_addr = head.sub_addr;
  assign sub_size = head.sub_size;
  assign sub_is_write = head.sub_is_write;
  assign sub_opcode = head.sub_opcode;
  assign context_id = head.context_id;
  assign word_index = head.word_index;
  assign burst_done = head.burst_done;
  assign last = head.last;

endmodule

>>> src/bte_held_fifo.sv
// Completion tag queue with same-cycle bypass when empty.
// Depends on bte_pkg.
module bte_held_fifo #(
  parameter int DEPTH = bte_pkg::HELD_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  bte_pkg::fifo_ctl_t  ctl,
  output bte_pkg::fifo_sts_t  sts
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bte_pkg::tag_t  mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;
  logic           bypass;

  assign do_push = ctl.push_req && (count < CW'(DEPTH));
  assign bypass = (count == '0);
  assign do_pop = ctl.pop_req && (!bypass || do_push);
  assign sts.pop_valid = do_pop;
  assign sts.pop_tag = bypass ? ctl.push_tag : mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push && !(bypass && do_pop)) begin
      mem[wr_ptr] <= ctl.push_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (bypass) begin
        if (do_push && !do_pop) begin
          wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
          count <= count + 1'b1;
        end
      end else begin
        if (do_push) begin
          wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
        end
        if (do_pop) begin
          rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
          count <= count + 1'b1;
        end else if (!do_push && do_pop) begin
          count <= count - 1'b1;
        end
      end
    end
  end

endmodule

>>> src/bte_core.sv
// Per-cycle context, lane and issue logic with its state registers.
// Depends on bte_pkg.
module bte_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic                 fire,
  input  logic                 cmd,
  input  logic [31:0]          req_addr,
  input  logic [6:0]           req_size,
  input  logic                 req_is_write,
  input  logic [3:0]           req_opcode,
  input  logic [3:0]           lane_grant_mask,
  input  logic [3:0]           lane_reopen_mask,
  input  logic                 done_valid,
  input  logic                 done_context,
  input  logic [3:0]           done_word,
  input  logic                 upstream_ready,
  output bte_pkg::fifo_ctl_t   fifo_ctl,
  input  bte_pkg::fifo_sts_t   fifo_sts,
  output bte_pkg::result_t     res [bte_pkg::MAX_RESULTS],
  output logic [bte_pkg::RES_CW-1:0] res_count
);

  localparam int NL = bte_pkg::NUM_LANES;

  logic        interleave;
  logic [1:0]  busy;
  logic [31:0] base [2];
  logic [6:0]  csize [2];
  logic [1:0]  cwr;
  logic [3:0]  cop [2];
  logic [4:0]  issued [2];
  logic [4:0]  completed [2];
  logic        rr;
  logic [NL-1:0] blocked;
  logic [NL-1:0] pk_valid;
  logic [NL-1:0] pk_ctx;
  logic [3:0]  pk_word [NL];

  logic [1:0]  busy_next;
  logic [31:0] base_next [2];
  logic [6:0]  csize_next [2];
  logic [1:0]  cwr_next;
  logic [3:0]  cop_next [2];
  logic [4:0]  issued_next [2];
  logic [4:0]  completed_next [2];
  logic        rr_next;
  logic [NL-1:0] blocked_next;
  logic [NL-1:0] pk_valid_next;
  logic [NL-1:0] pk_ctx_next;
  logic [3:0]  pk_word_next [NL];

  logic        take;
  logic        take_sel;

  always_comb begin
    logic ok;
    ok = cmd && (req_size != 7'd0) && ({1'b0, req_size} <= bte_pkg::MAX_BYTES);
    if (ok && !(bte_pkg::ctx_words(req_size) > 6'd1 && !req_is_write) && (|busy)) begin
      ok = 1'b0;
    end
    take = 1'b0;
    take_sel = 1'b0;
    if (ok && !busy[0]) begin
      take = 1'b1;
    end else if (ok && interleave && !busy[1]) begin
      take = 1'b1;
      take_sel = 1'b1;
    end
  end

  always_comb begin
    logic [bte_pkg::RES_CW-1:0] n;
    logic [NL-1:0] used;
    logic found_c;
    logic cs;
    logic found_l;
    logic [1:0] ln;
    logic [3:0] w;
    logic bc;
    logic fin;
    n = '0;
    used = '0;
    found_c = 1'b0;
    cs = 1'b0;
    found_l = 1'b0;
    ln = '0;
    w = '0;
    bc = 1'b0;
    fin = 1'b0;
    for (int i = 0; i < bte_pkg::MAX_RESULTS; i++) begin
      res[i] = '0;
    end
    busy_next = busy;
    base_next = base;
    csize_next = csize;
    cwr_next = cwr;
    cop_next = cop;
    issued_next = issued;
    completed_next = completed;
    rr_next = rr;
    pk_valid_next = pk_valid;
    pk_ctx_next = pk_ctx;
    pk_word_next = pk_word;
    blocked_next = blocked & ~lane_reopen_mask[NL-1:0];

    if (cmd) begin
      if (take) begin
        busy_next[take_sel] = 1'b1;
        base_next[take_sel] = req_addr;
        csize_next[take_sel] = req_size;
        cwr_next[take_sel] = req_is_write;
        cop_next[take_sel] = req_opcode;
        issued_next[take_sel] = '0;
        completed_next[take_sel] = '0;
        res[n].kind = bte_pkg::KIND_ACCEPT;
        res[n].context_id = take_sel;
      end else begin
        res[n].kind = bte_pkg::KIND_DENY;
      end
      n = n + 1'b1;
    end

    for (int l = 0; l < NL; l++) begin
      if (pk_valid[l] && !blocked_next[l]) begin
        used[l] = 1'b1;
        res[n] = bte_pkg::make_offer(2'(l), base_next[pk_ctx[l]], csize_next[pk_ctx[l]],
                                     cwr_next[pk_ctx[l]], cop_next[pk_ctx[l]],
                                     pk_ctx[l], pk_word[l]);
        n = n + 1'b1;
        if (lane_grant_mask[l]) begin
          pk_valid_next[l] = 1'b0;
        end else begin
          blocked_next[l] = 1'b1;
        end
      end
    end

    for (int it = 0; it < NL; it++) begin
      found_c = 1'b0;
      cs = 1'b0;
      for (int c = 0; c < 2; c++) begin
        if (!found_c && busy_next[rr_next ^ 1'(c)] &&
            {1'b0, issued_next[rr_next ^ 1'(c)]} <
            bte_pkg::ctx_words(csize_next[rr_next ^ 1'(c)])) begin
          found_c = 1'b1;
          cs = rr_next ^ 1'(c);
        end
      end
      found_l = 1'b0;
      ln = '0;
      for (int l = 0; l < NL; l++) begin
        if (!found_l && !blocked_next[l] && !pk_valid_next[l] && !used[l]) begin
          found_l = 1'b1;
          ln = 2'(l);
        end
      end
      if (found_c && found_l) begin
        rr_next = ~cs;
        w = issued_next[cs][3:0];
        issued_next[cs] = issued_next[cs] + 1'b1;
        used[ln] = 1'b1;
        res[n] = bte_pkg::make_offer(ln, base_next[cs], csize_next[cs], cwr_next[cs],
                                     cop_next[cs], cs, w);
        n = n + 1'b1;
        if (!lane_grant_mask[ln]) begin
          pk_valid_next[ln] = 1'b1;
          pk_ctx_next[ln] = cs;
          pk_word_next[ln] = w;
          blocked_next[ln] = 1'b1;
        end
      end
    end

    if (fifo_sts.pop_valid) begin
      bc = fifo_sts.pop_tag.ctx;
      if (busy_next[bc]) begin
        completed_next[bc] = completed_next[bc] + 1'b1;
        if ({1'b0, completed_next[bc]} >= bte_pkg::ctx_words(csize_next[bc])) begin
          busy_next[bc] = 1'b0;
          fin = 1'b1;
        end
      end
      res[n].kind = bte_pkg::KIND_BEAT;
      res[n].context_id = bc;
      res[n].word_index = fifo_sts.pop_tag.word;
      res[n].burst_done = fin;
      n = n + 1'b1;
    end

    if (n != '0) begin
      res[n - 1'b1].last = 1'b1;
    end
    res_count = n;
  end

  // completion is checked against context state after this cycle's accept
  always_comb begin
    fifo_ctl.push_req = fire && done_valid &&
                        (busy[done_context] || (take && (take_sel == done_context)));
    fifo_ctl.push_tag.ctx = done_context;
    fifo_ctl.push_tag.word = done_word;
    fifo_ctl.pop_req = fire && upstream_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interleave <= 1'b0;
    end else if (cfg_we) begin
      interleave <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
      cwr <= '0;
      rr <= 1'b0;
      blocked <= '0;
      pk_valid <= '0;
      pk_ctx <= '0;
      for (int c = 0; c < 2; c++) begin
        base[c] <= '0;
        csize[c] <= '0;
        cop[c] <= '0;
        issued[c] <= '0;
        completed[c] <= '0;
      end
      for (int l = 0; l < NL; l++) begin
        pk_word[l] <= '0;
      end
    end else if (fire) begin
      busy <= busy_next;
      base <= base_next;
      csize <= csize_next;
      cwr <= cwr_next;
      cop <= cop_next;
      issued <= issued_next;
      completed <= completed_next;
      rr <= rr_next;
      blocked <= blocked_next;
      pk_valid <= pk_valid_next;
      pk_ctx <= pk_ctx_next;
      pk_word <= pk_word_next;
    end
  end

endmodule

>>> src/bte_result_buf.sv
// Holds the results of one transaction and hands them out one per cycle while out_ready is high.
// Depends on bte_pkg.
module bte_result_buf (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  bte_pkg::result_t              res [bte_pkg::MAX_RESULTS],
  input  logic [bte_pkg::RES_CW-1:0]    res_count,
  output logic                          space,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bte_pkg::result_t              head
);

  localparam int CW = bte_pkg::RES_CW;

  bte_pkg::result_t slots [bte_pkg::MAX_RESULTS];
  logic [CW-1:0]    cnt;
  logic [CW-1:0]    idx;
  logic [CW-1:0]    idx_inc;

  assign idx_inc = idx + 1'b1;
  assign out_valid = (idx != cnt);
  assign space = !out_valid || (idx_inc == cnt && out_ready);
  assign head = slots[idx[$clog2(bte_pkg::MAX_RESULTS)-1:0]];

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (load) begin
      cnt <= res_count;
      idx <= '0;
    end else if (out_valid && out_ready) begin
      idx <= idx_inc;
    end
  end

endmodule
